// ===== hw/rtl/csb_pkg.sv =====
`default_nettype none

package csb_pkg;

  localparam int NUM_SEMS  = 8;
  localparam int NUM_TASKS = 16;

  localparam int SEM_W   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int POS_W   = $clog2(NUM_TASKS);
  localparam int LEN_W   = $clog2(NUM_TASKS + 1);
  localparam int WADDR_W = $clog2(NUM_SEMS * NUM_TASKS);
  localparam int COUNT_W = 15;
  localparam int TASK_W  = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    REQ_INIT    = 2'd0,
    REQ_WAIT    = 2'd1,
    REQ_POST    = 2'd2,
    REQ_DESTROY = 2'd3
  } csb_req_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_INVAL  = 3'd1,
    ST_NOINIT = 3'd2,
    ST_NOSLOT = 3'd3,
    ST_FULL   = 3'd4
  } csb_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_POP,
    FSM_DRAIN
  } csb_fsm_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         sem_index;
    logic signed [15:0] initial_count;
    logic [3:0]         caller_task;
  } csb_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] sem_handle;
    logic       caller_blocked;
    logic       woken_valid;
    logic [3:0] woken_task;
    logic       last;
  } csb_res_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   head;
    logic [POS_W-1:0]   tail;
    logic [LEN_W-1:0]   len;
  } csb_slot_t;

  localparam int SLOT_W = $bits(csb_slot_t);

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] res;
    if (pos == POS_W'(NUM_TASKS - 1)) begin
      res = '0;
    end else begin
      res = pos + POS_W'(1);
    end
    return res;
  endfunction

  function automatic logic [WADDR_W-1:0] waiter_addr(input logic [SEM_W-1:0] sem,
                                                     input logic [POS_W-1:0] pos);
    logic [WADDR_W-1:0] base;
    base = WADDR_W'(WADDR_W'(sem) * WADDR_W'(NUM_TASKS));
    return WADDR_W'(base + WADDR_W'(pos));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/counting_semaphore_bank_core.sv =====
// Channel   Ports                         Handshake
// request   start, busy, req_i            beat taken when start is high and busy is low
// result    result_valid_o, result_o      one beat per cycle while result_valid_o is high
//
// A request reads its slot from the slot memory on the accept edge and is decided in
// the next cycle, in the FSM_EXEC state.
// A post that wakes a task adds the FSM_POP state for the wait queue memory read.
// A destroy with n waiters gives n results, one per waiter, in the FSM_DRAIN state after the decide state.
// After reset every slot is free and the block is ready at once.
// The receiver cannot stall; each result is shown for exactly one cycle.

`default_nettype none

module counting_semaphore_bank_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire csb_pkg::csb_req_t req_i,
  output logic                   result_valid_o,
  output csb_pkg::csb_res_t      result_o
);

  csb_pkg::csb_fsm_e state_q, state_d;
  csb_pkg::csb_req_t req_q;
  csb_pkg::csb_slot_t work_q, work_d;
  csb_pkg::csb_res_t res_q, res_d;
  logic res_valid_q, res_valid_d;
  logic [csb_pkg::NUM_SEMS-1:0] in_use_q, in_use_d;

  logic accept;
  logic [csb_pkg::SEM_W-1:0] sem;
  logic idx_bad, task_bad, slot_live, has_waiters;
  logic free_found;
  logic [csb_pkg::SEM_W-1:0] free_idx;

  logic slot_we;
  logic [csb_pkg::SEM_W-1:0] slot_waddr;
  csb_pkg::csb_slot_t slot_wdata, slot_rdata;
  logic [csb_pkg::SLOT_W-1:0] slot_rbits;

  logic wq_we, wq_re;
  logic [csb_pkg::WADDR_W-1:0] wq_waddr, wq_raddr;
  logic [csb_pkg::TASK_W-1:0] wq_rdata;

  assign busy   = (state_q != csb_pkg::FSM_IDLE);
  assign accept = start && !busy;

  csb_ram #(
    .WIDTH(csb_pkg::SLOT_W),
    .DEPTH(csb_pkg::NUM_SEMS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .re_i   (accept),
    .raddr_i(req_i.sem_index[csb_pkg::SEM_W-1:0]),
    .rdata_o(slot_rbits)
  );

  assign slot_rdata = csb_pkg::csb_slot_t'(slot_rbits);

  csb_ram #(
    .WIDTH(csb_pkg::TASK_W),
    .DEPTH(csb_pkg::NUM_SEMS * csb_pkg::NUM_TASKS)
  ) u_waiter_ram (
    .clk_i  (clk_i),
    .we_i   (wq_we),
    .waddr_i(wq_waddr),
    .wdata_i(req_q.caller_task),
    .re_i   (wq_re),
    .raddr_i(wq_raddr),
    .rdata_o(wq_rdata)
  );

  always_comb begin
    sem         = req_q.sem_index[csb_pkg::SEM_W-1:0];
    idx_bad     = ({1'b0, req_q.sem_index} >= 5'(csb_pkg::NUM_SEMS));
    task_bad    = ({1'b0, req_q.caller_task} >= 5'(csb_pkg::NUM_TASKS));
    slot_live   = !idx_bad && in_use_q[sem];
    has_waiters = (slot_rdata.len != '0);
    free_found  = 1'b0;
    free_idx    = '0;
    for (int i = csb_pkg::NUM_SEMS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = csb_pkg::SEM_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      csb_pkg::FSM_IDLE: begin
        if (accept) begin
          state_d = csb_pkg::FSM_EXEC;
        end
      end
      csb_pkg::FSM_EXEC: begin
        state_d = csb_pkg::FSM_IDLE;
        if (slot_live && has_waiters) begin
          if (req_q.req_type == csb_pkg::REQ_POST) begin
            state_d = csb_pkg::FSM_POP;
          end else if (req_q.req_type == csb_pkg::REQ_DESTROY) begin
            state_d = csb_pkg::FSM_DRAIN;
          end
        end
      end
      csb_pkg::FSM_POP: begin
        state_d = csb_pkg::FSM_IDLE;
      end
      csb_pkg::FSM_DRAIN: begin
        if (work_q.len == '0) begin
          state_d = csb_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = csb_pkg::FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    slot_we     = 1'b0;
    slot_waddr  = sem;
    slot_wdata  = slot_rdata;
    wq_we       = 1'b0;
    wq_waddr    = csb_pkg::waiter_addr(sem, slot_rdata.tail);
    wq_re       = 1'b0;
    wq_raddr    = csb_pkg::waiter_addr(sem, slot_rdata.head);
    in_use_d    = in_use_q;
    work_d      = work_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    res_d.last  = 1'b1;
    case (state_q)
      csb_pkg::FSM_EXEC: begin
        res_valid_d = 1'b1;
        if (req_q.req_type == csb_pkg::REQ_INIT) begin
          if (req_q.initial_count[15]) begin
            res_d.status = csb_pkg::ST_INVAL;
          end else if (!free_found) begin
            res_d.status = csb_pkg::ST_NOSLOT;
          end else begin
            slot_we            = 1'b1;
            slot_waddr         = free_idx;
            slot_wdata         = '0;
            slot_wdata.count   = req_q.initial_count[csb_pkg::COUNT_W-1:0];
            in_use_d[free_idx] = 1'b1;
            res_d.status       = csb_pkg::ST_OK;
            res_d.sem_handle   = 3'(free_idx);
          end
        end else if (idx_bad) begin
          res_d.status = csb_pkg::ST_INVAL;
        end else if (!slot_live) begin
          res_d.status = csb_pkg::ST_NOINIT;
        end else begin
          case (req_q.req_type)
            csb_pkg::REQ_WAIT: begin
              if (task_bad) begin
                res_d.status = csb_pkg::ST_INVAL;
              end else if (slot_rdata.count != '0) begin
                slot_we          = 1'b1;
                slot_wdata.count = slot_rdata.count - csb_pkg::COUNT_W'(1);
              end else if (slot_rdata.len >= csb_pkg::LEN_W'(csb_pkg::NUM_TASKS)) begin
                res_d.status = csb_pkg::ST_FULL;
              end else begin
                wq_we                = 1'b1;
                slot_we              = 1'b1;
                slot_wdata.tail      = csb_pkg::next_pos(slot_rdata.tail);
                slot_wdata.len       = slot_rdata.len + csb_pkg::LEN_W'(1);
                res_d.caller_blocked = 1'b1;
              end
            end
            csb_pkg::REQ_POST: begin
              if (has_waiters) begin
                res_valid_d = 1'b0;
                wq_re       = 1'b1;
                work_d      = slot_rdata;
                work_d.head = csb_pkg::next_pos(slot_rdata.head);
                work_d.len  = slot_rdata.len - csb_pkg::LEN_W'(1);
              end else if (slot_rdata.count != csb_pkg::COUNT_MAX) begin
                slot_we          = 1'b1;
                slot_wdata.count = slot_rdata.count + csb_pkg::COUNT_W'(1);
              end
            end
            csb_pkg::REQ_DESTROY: begin
              if (has_waiters) begin
                res_valid_d = 1'b0;
                wq_re       = 1'b1;
                work_d      = slot_rdata;
                work_d.head = csb_pkg::next_pos(slot_rdata.head);
                work_d.len  = slot_rdata.len - csb_pkg::LEN_W'(1);
              end else begin
                in_use_d[sem] = 1'b0;
              end
            end
            default: begin
              res_d.status = csb_pkg::ST_INVAL;
            end
          endcase
        end
      end
      csb_pkg::FSM_POP: begin
        res_valid_d       = 1'b1;
        res_d.woken_valid = 1'b1;
        res_d.woken_task  = wq_rdata;
        slot_we           = 1'b1;
        slot_wdata        = work_q;
      end
      csb_pkg::FSM_DRAIN: begin
        res_valid_d       = 1'b1;
        res_d.woken_valid = 1'b1;
        res_d.woken_task  = wq_rdata;
        res_d.last        = (work_q.len == '0);
        if (work_q.len != '0) begin
          wq_re       = 1'b1;
          wq_raddr    = csb_pkg::waiter_addr(sem, work_q.head);
          work_d.head = csb_pkg::next_pos(work_q.head);
          work_d.len  = work_q.len - csb_pkg::LEN_W'(1);
        end else begin
          in_use_d[sem] = 1'b0;
        end
      end
      default: begin
        res_d.last = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csb_pkg::FSM_IDLE;
      in_use_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_use_q    <= in_use_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    work_q <= work_d;
    res_q  <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("Accepted request did not raise busy.");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q != csb_pkg::FSM_IDLE))
    else $error("Result appeared without a request in progress.");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> (state_q == csb_pkg::FSM_IDLE))
    else $error("Final result beat while the request is still running.");

  a_woken_not_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(result_o.woken_valid && result_o.caller_blocked))
    else $error("Result both wakes a task and blocks the caller.");

endmodule

`default_nettype wire

// ===== hw/rtl/csb_ram.sv =====
`default_nettype none

module csb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
